### rtl/pdcrx_pkg.sv
// Shared types, constants and defaults for the byte-stuffed packet receiver.
// No dependencies; every other file of the block but the checker takes names from here.
package pdcrx_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 32;
  localparam int unsigned IDX_W_MAX         = 6;
  localparam int unsigned RUN_W             = 5;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 16;

  localparam logic [RUN_W-1:0] MAX_RUN          = 5'd31;
  localparam logic [15:0]      IDLE_TIMEOUT_RST = 16'd100;

  localparam logic       REQ_TICK  = 1'b1;
  localparam logic [7:0] SYNC_BYTE = 8'h00;
  localparam logic [7:0] ESC_BYTE  = 8'h80;
  localparam logic [7:0] ESC_ZERO  = 8'h81;
  localparam logic [7:0] ESC_ESC   = 8'h82;
  localparam logic [7:0] BCAST     = 8'hFF;
  localparam logic [7:0] CRC_POLY  = 8'h8C;
  localparam logic [7:0] NIBBLE_LO = 8'h0F;
  localparam logic [7:0] NIBBLE_HI = 8'hF0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ADDR     = 2'd0,
    REG_SNIFF        = 2'd1,
    REG_SKIP_CRC     = 2'd2,
    REG_IDLE_TIMEOUT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  own_address;
    logic        sniff_mode;
    logic        skip_crc_check;
    logic [15:0] idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic [7:0]           dst;
    logic [7:0]           src;
    logic [IDX_W_MAX-1:0] len;
    logic [7:0]           cmd;
    logic                 bank;
  } desc_t;

  typedef struct packed {
    logic                 en;
    logic                 bank;
    logic [IDX_W_MAX-1:0] idx;
    logic [7:0]           data;
  } mem_wr_t;

endpackage

### rtl/pdcrx_if.sv
// Valid/ready channel interfaces: line input, packet results and register writes.
// Depends on pdcrx_pkg for the register port widths.
interface pdcrx_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface pdcrx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] dst_address;
  logic [7:0] src_address;
  logic [4:0] payload_len;
  logic [7:0] command_id;
  logic [7:0] payload_byte;
  logic [4:0] byte_index;
  logic       has_payload;
  logic       last;

  modport source (output valid, output dst_address, output src_address, output payload_len,
                  output command_id, output payload_byte, output byte_index,
                  output has_payload, output last, input ready);
  modport sink   (input valid, input dst_address, input src_address, input payload_len,
                  input command_id, input payload_byte, input byte_index,
                  input has_payload, input last, output ready);
  modport monitor (input valid, input ready, input dst_address, input src_address,
                   input payload_len, input command_id, input payload_byte,
                   input byte_index, input has_payload, input last);
endinterface

interface pdcrx_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pdcrx_pkg::CFG_IDX_W-1:0]  index;
  logic [pdcrx_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/packet_deframer_crc8_rx_unit.sv
// Receiver for byte-stuffed serial packets with a CRC-8 check. Line bytes and timeout
// ticks are taken as they come; input stalls only while two good packets still wait to be
// played out, since each of the two payload memory banks holds one packet. A good packet
// leaves as one result per payload byte (at most 31), or one result if its payload is
// empty; each result passes through a payload memory read state and a show state, and
// each packet also passes through an idle state that takes its descriptor from the queue.
// Registers: 0 own address, 1 sniff mode, 2 skip CRC check, 3 idle timeout (reset 100).
module packet_deframer_crc8_rx_unit #(
  parameter int unsigned PAYLOAD_BYTES = pdcrx_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pdcrx_in_if.sink     in_i,
  pdcrx_out_if.source  out_o,
  pdcrx_cfg_if.sink    cfg_i
);
  pdcrx_pkg::cfg_t    cfg_q;
  pdcrx_pkg::desc_t   push_desc, head;
  pdcrx_pkg::mem_wr_t mem_wr;
  logic               push, pop, q_full, q_empty;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address    <= '0;
      cfg_q.sniff_mode     <= 1'b0;
      cfg_q.skip_crc_check <= 1'b0;
      cfg_q.idle_timeout   <= pdcrx_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pdcrx_pkg::REG_OWN_ADDR:     cfg_q.own_address    <= cfg_i.data[7:0];
        pdcrx_pkg::REG_SNIFF:        cfg_q.sniff_mode     <= cfg_i.data[0];
        pdcrx_pkg::REG_SKIP_CRC:     cfg_q.skip_crc_check <= cfg_i.data[0];
        pdcrx_pkg::REG_IDLE_TIMEOUT: cfg_q.idle_timeout   <= cfg_i.data[15:0];
        default: begin
        end
      endcase
    end
  end

  pdcrx_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .desc_o   (push_desc),
    .wr_o     (mem_wr)
  );

  pdcrx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pdcrx_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .wr_i      (mem_wr),
    .out_o     (out_o)
  );
endmodule

### rtl/pdcrx_queue.sv
// Two-entry descriptor queue between the deframer front and the emitter back.
// An entry stays until its whole run is delivered, so it also marks its bank busy.
module pdcrx_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pdcrx_pkg::desc_t desc_i,
  input  logic             pop_i,
  output pdcrx_pkg::desc_t head_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = $clog2(pdcrx_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(pdcrx_pkg::QUEUE_DEPTH + 1);

  pdcrx_pkg::desc_t   entry_q [pdcrx_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(pdcrx_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= desc_i;
    end
  end
endmodule

### rtl/pdcrx_front.sv
// Deframer front: unstuffs line bytes, tracks the frame fields, checks CRC-8 and timeouts.
// Depends on pdcrx_pkg and pdcrx_in_if; pushes descriptors and payload writes.
module pdcrx_front #(
  parameter int unsigned PAYLOAD_BYTES = pdcrx_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pdcrx_in_if.sink           in_i,
  input  pdcrx_pkg::cfg_t    cfg_i,
  input  logic               q_full_i,
  output logic               push_o,
  output pdcrx_pkg::desc_t   desc_o,
  output pdcrx_pkg::mem_wr_t wr_o
);
  localparam logic [7:0] LEN_LIMIT = 8'(PAYLOAD_BYTES - 1);

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_DST  = 6'b000010,
    PH_SRC  = 6'b000100,
    PH_LEN  = 6'b001000,
    PH_CMD  = 6'b010000,
    PH_PAY  = 6'b100000
  } phase_e;

  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int n = 0; n < 8; n++) begin
      v = v[0] ? ((v >> 1) ^ pdcrx_pkg::CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d, drop_q, drop_d, bank_q, bank_d;
  logic [7:0]  crc_q, crc_d, cnt_q, cnt_d;
  logic [7:0]  dst_q, dst_d, src_q, src_d, len_q, len_d, cmd_q, cmd_d;
  logic [15:0] busy_q, busy_d;

  logic       accept;
  logic [7:0] raw, b, data_v, crc_new;
  logic       addr_ok;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign raw        = in_i.rx_byte;

  always_comb begin
    b = raw;
    if (esc_q && raw == pdcrx_pkg::ESC_ZERO) begin
      b = pdcrx_pkg::SYNC_BYTE;
    end else if (esc_q && raw == pdcrx_pkg::ESC_ESC) begin
      b = pdcrx_pkg::ESC_BYTE;
    end
  end

  assign addr_ok = cfg_i.sniff_mode
      || (((b & pdcrx_pkg::NIBBLE_LO) == pdcrx_pkg::NIBBLE_LO)
          && ((b & pdcrx_pkg::NIBBLE_HI) == (cfg_i.own_address & pdcrx_pkg::NIBBLE_HI)))
      || (b == pdcrx_pkg::BCAST)
      || (b == cfg_i.own_address);

  assign data_v  = (phase_q == PH_DST || phase_q == PH_SRC) ? b : ~b;
  assign crc_new = crc8_update((phase_q == PH_DST) ? 8'h00 : crc_q, data_v);

  assign desc_o = '{dst: dst_q, src: src_q, len: pdcrx_pkg::IDX_W_MAX'(len_q),
                    cmd: cmd_q, bank: bank_q};

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    drop_d  = drop_q;
    bank_d  = bank_q;
    crc_d   = crc_q;
    cnt_d   = cnt_q;
    dst_d   = dst_q;
    src_d   = src_q;
    len_d   = len_q;
    cmd_d   = cmd_q;
    busy_d  = busy_q;
    push_o  = 1'b0;
    wr_o    = '0;
    if (accept) begin
      if (in_i.req_type == pdcrx_pkg::REQ_TICK) begin
        if (phase_q == PH_IDLE) begin
          busy_d = '0;
        end else if (busy_q < cfg_i.idle_timeout) begin
          busy_d = busy_q + 16'd1;
        end else begin
          busy_d  = '0;
          phase_d = PH_IDLE;
        end
      end else if (raw == pdcrx_pkg::SYNC_BYTE) begin
        phase_d = PH_DST;
        esc_d   = 1'b0;
        drop_d  = 1'b0;
      end else if (raw == pdcrx_pkg::ESC_BYTE) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        unique case (phase_q)
          PH_IDLE: begin
          end
          PH_DST: begin
            drop_d  = !addr_ok;
            dst_d   = b;
            crc_d   = crc_new;
            phase_d = PH_SRC;
          end
          PH_SRC: begin
            src_d   = b;
            crc_d   = crc_new;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            if (data_v > LEN_LIMIT) begin
              drop_d = 1'b1;
            end
            len_d   = data_v;
            crc_d   = crc_new;
            phase_d = PH_CMD;
          end
          PH_CMD: begin
            cmd_d   = data_v;
            cnt_d   = '0;
            crc_d   = crc_new;
            phase_d = PH_PAY;
          end
          PH_PAY: begin
            if (cnt_q >= len_q) begin
              phase_d = PH_IDLE;
              if ((cfg_i.skip_crc_check || crc_q == b) && !drop_q) begin
                push_o = 1'b1;
                bank_d = !bank_q;
              end
            end else begin
              if (!drop_q && cnt_q < LEN_LIMIT) begin
                wr_o.en   = 1'b1;
                wr_o.bank = bank_q;
                wr_o.idx  = pdcrx_pkg::IDX_W_MAX'(cnt_q);
                wr_o.data = data_v;
              end
              cnt_d = cnt_q + 8'd1;
              crc_d = crc_new;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      esc_q   <= 1'b0;
      drop_q  <= 1'b0;
      bank_q  <= 1'b0;
      crc_q   <= '0;
      cnt_q   <= '0;
      dst_q   <= '0;
      src_q   <= '0;
      len_q   <= '0;
      cmd_q   <= '0;
      busy_q  <= '0;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      drop_q  <= drop_d;
      bank_q  <= bank_d;
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
      dst_q   <= dst_d;
      src_q   <= src_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      busy_q  <= busy_d;
    end
  end
endmodule

### rtl/pdcrx_back.sv
// Emitter back: two-bank payload memory; plays one result per payload byte, one if empty.
// Depends on pdcrx_pkg and pdcrx_out_if; reads descriptors from the queue head.
module pdcrx_back #(
  parameter int unsigned PAYLOAD_BYTES = pdcrx_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdcrx_pkg::desc_t   head_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  input  pdcrx_pkg::mem_wr_t wr_i,
  pdcrx_out_if.source        out_o
);
  localparam int unsigned IDX_W     = $clog2(PAYLOAD_BYTES);
  localparam int unsigned MEM_DEPTH = 2 * (2 ** IDX_W);
  localparam int unsigned RUN_W     = pdcrx_pkg::RUN_W;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_SHOW = 3'b100
  } back_state_e;

  logic [7:0]       mem_q [MEM_DEPTH];
  logic [7:0]       rd_q;
  back_state_e      state_q, state_d;
  logic [RUN_W-1:0] idx_q, idx_d;

  logic [IDX_W:0]   rd_addr;
  logic [7:0]       len8;
  logic             empty_pkt, is_last;
  logic [RUN_W-1:0] last_idx;

  assign rd_addr   = {head_i.bank, IDX_W'(idx_q)};
  assign len8      = 8'(head_i.len);
  assign empty_pkt = (len8 == 8'd0);
  assign last_idx  = (len8 > 8'(pdcrx_pkg::MAX_RUN)) ? pdcrx_pkg::MAX_RUN - 1'b1
                                                      : RUN_W'(len8 - 8'd1);
  assign is_last   = empty_pkt || (idx_q == last_idx);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[{wr_i.bank, wr_i.idx[IDX_W-1:0]}] <= wr_i.data;
    end
    if (state_q == BK_READ) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign out_o.valid        = (state_q == BK_SHOW);
  assign out_o.dst_address  = head_i.dst;
  assign out_o.src_address  = head_i.src;
  assign out_o.payload_len  = RUN_W'(head_i.len);
  assign out_o.command_id   = head_i.cmd;
  assign out_o.payload_byte = empty_pkt ? 8'h00 : rd_q;
  assign out_o.byte_index   = idx_q;
  assign out_o.has_payload  = !empty_pkt;
  assign out_o.last         = is_last;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          idx_d   = '0;
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        state_d = BK_SHOW;
      end
      BK_SHOW: begin
        if (out_o.ready) begin
          if (is_last) begin
            pop_o   = 1'b1;
            state_d = BK_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = BK_READ;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end
endmodule

### rtl/pdcrx_checker.sv
// Port-level checks on the result channel of the packet receiver, bound to the top level.
// Depends on the result channel signals of the top level; observes only.
module pdcrx_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [7:0] dst_address_i,
  input logic [7:0] src_address_i,
  input logic [4:0] payload_len_i,
  input logic [7:0] command_id_i,
  input logic [7:0] payload_byte_i,
  input logic [4:0] byte_index_i,
  input logic       has_payload_i,
  input logic       last_i
);
  logic out_beat;
  assign out_beat = valid_i && ready_i;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(payload_byte_i)
      && $stable(byte_index_i) && $stable(last_i))
    else $error("result changed while stalled");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !has_payload_i |-> last_i && byte_index_i == 5'd0
      && payload_byte_i == 8'h00 && payload_len_i == 5'd0)
    else $error("empty packet result malformed");

  a_header_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !last_i |=> $stable(dst_address_i) && $stable(src_address_i)
      && $stable(command_id_i) && $stable(payload_len_i))
    else $error("packet header changed within a run");

  a_run_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && byte_index_i == 5'd30 |-> last_i)
    else $error("run longer than 31 results");
endmodule

bind packet_deframer_crc8_rx_unit pdcrx_port_checker u_pdcrx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (out_o.valid),
  .ready_i        (out_o.ready),
  .dst_address_i  (out_o.dst_address),
  .src_address_i  (out_o.src_address),
  .payload_len_i  (out_o.payload_len),
  .command_id_i   (out_o.command_id),
  .payload_byte_i (out_o.payload_byte),
  .byte_index_i   (out_o.byte_index),
  .has_payload_i  (out_o.has_payload),
  .last_i         (out_o.last)
);
